/* hw/rtl/psd_pkg.sv */
// shared types and constants for the point to segment squared distance block
// depends on nothing; used by psd_div_cell and point_segment_distance_sq
package psd_pkg;

	localparam int COORD_W    = 16;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int LEN_W      = 2 * COORD_W + 2;
	localparam int PARAM_FRAC = 16;
	localparam int PARAM_W    = PARAM_FRAC + 1;
	localparam int LIMIT_W    = 16;
	localparam int DIST_W     = 34;
	localparam int DROP       = PARAM_FRAC + 4 - 8;

	// one word travelling down the divider row
	typedef struct packed {
		logic signed [DIFF_W-1:0] ax;
		logic signed [DIFF_W-1:0] ay;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic                     deg;
		logic [DIST_W-1:0]        deg_dist;
		logic [LEN_W-1:0]         len;
		logic [LEN_W-1:0]         rem;
		logic [PARAM_FRAC-1:0]    quot;
		logic                     t_one;
	} psd_cell_t;

endpackage

/* hw/rtl/point_segment_distance_sq.sv */
// top level: squared distance from a point to a line segment, fixed point
// depends on psd_pkg and psd_div_cell
//
// usage:
// - input words arrive on s_tvalid/s_tready/s_tdata, six signed Q12.4
//   coordinates: point, segment start, segment end
// - results leave on m_tvalid/m_tready/m_tdata/m_tuser: squared distance
//   with 8 fractional bits in m_tdata, degenerate flag in m_tuser
// - one word per cycle is taken while the receiver keeps up
// - the projection parameter comes from a row of 16 division cells, one
//   quotient bit each, which sets most of the latency
// - when m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops in the same cycle; nothing is lost
// - reset clears all valid flags and sets degenerate_limit to zero
// - cfg_wen/cfg_wdata write degenerate_limit; write only when idle
module point_segment_distance_sq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // point_x, point_y, start_x, start_y, end_x, end_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // distance_sq, zero padding
	output logic        m_tuser   // degenerate
);

	localparam int NCELL = psd_pkg::PARAM_FRAC;
	localparam int DW    = psd_pkg::DIFF_W;
	localparam int LW    = psd_pkg::LEN_W;

	logic                      ce;
	logic [psd_pkg::LIMIT_W-1:0] limit_q;

	logic signed [15:0] px, py, sx, sy, ex, ey;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [DW-1:0]      ax_s1, ay_s1, dx_s1, dy_s1;
	logic signed [DW-1:0]      ax_s2, ay_s2, dx_s2, dy_s2;
	logic signed [2*DW-1:0]    sqdx_s2, sqdy_s2, axdx_s2, aydy_s2, sqax_s2, sqay_s2;

	logic [LW-1:0]             len_c, degd_c;
	logic signed [LW:0]        dot_c;
	psd_pkg::psd_cell_t        head_c;
	psd_pkg::psd_cell_t        head_s3;

	psd_pkg::psd_cell_t        cell_w [NCELL+1];
	logic                      cell_v [NCELL+1];

	logic [psd_pkg::PARAM_W-1:0] t_c;
	logic signed [psd_pkg::PARAM_W+DW-1:0] prx_s4, pry_s4;
	logic signed [DW-1:0]      ax_s4, ay_s4;
	logic                      deg_s4, deg_s5, deg_s6, deg_s7;
	logic [psd_pkg::DIST_W-1:0] degd_s4, degd_s5, degd_s6;

	logic signed [DW+psd_pkg::PARAM_W+1:0] ox_c, oy_c;
	logic [DW+psd_pkg::PARAM_W+1:0]        mx_c, my_c;
	logic [23:0]               qx_s5, qy_s5;
	logic [47:0]               qqx_s6, qqy_s6;
	logic [48:0]               sum_c;
	logic [40:0]               sh_c;
	logic [psd_pkg::DIST_W-1:0] dist_c, dist_s7;

	// whole pipeline advances unless a result is stuck at the output
	assign ce       = m_tready || !v_s7;
	assign s_tready = ce;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	assign px = s_tdata[15:0];
	assign py = s_tdata[31:16];
	assign sx = s_tdata[47:32];
	assign sy = s_tdata[63:48];
	assign ex = s_tdata[79:64];
	assign ey = s_tdata[95:80];

	// valid flags of the plain stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (ce) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s4 <= cell_v[NCELL];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		if (ce) begin
			ax_s1 <= DW'(px) - DW'(sx);
			ay_s1 <= DW'(py) - DW'(sy);
			dx_s1 <= DW'(ex) - DW'(sx);
			dy_s1 <= DW'(ey) - DW'(sy);
		end
	end

	// stage 2: products
	always_ff @(posedge clk) begin
		if (ce) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			sqdx_s2 <= dx_s1 * dx_s1;
			sqdy_s2 <= dy_s1 * dy_s1;
			axdx_s2 <= ax_s1 * dx_s1;
			aydy_s2 <= ay_s1 * dy_s1;
			sqax_s2 <= ax_s1 * ax_s1;
			sqay_s2 <= ay_s1 * ay_s1;
		end
	end

	// stage 3: sums, degenerate test and clamping, divider head word
	always_comb begin
		len_c  = LW'(sqdx_s2) + LW'(sqdy_s2);
		degd_c = LW'(sqax_s2) + LW'(sqay_s2);
		dot_c  = (LW+1)'(axdx_s2) + (LW+1)'(aydy_s2);
		head_c          = '0;
		head_c.ax       = ax_s2;
		head_c.ay       = ay_s2;
		head_c.dx       = dx_s2;
		head_c.dy       = dy_s2;
		head_c.deg_dist = psd_pkg::DIST_W'(degd_c);
		head_c.len      = len_c;
		head_c.deg      = len_c <= LW'(limit_q);
		if (head_c.deg || dot_c <= 0) begin
			head_c.rem = '0;
		end else if (dot_c[LW-1:0] >= len_c) begin
			head_c.t_one = 1'b1;
		end else begin
			head_c.rem = dot_c[LW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ce) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			head_s3 <= head_c;
		end
	end

	// row of division cells
	assign cell_w[0] = head_s3;
	assign cell_v[0] = v_s3;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		psd_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ce     (ce),
			.vld_in (cell_v[i]),
			.d      (cell_w[i]),
			.vld_q  (cell_v[i+1]),
			.q      (cell_w[i+1])
		);
	end

	// stage 4: t times segment direction
	assign t_c = cell_w[NCELL].t_one ? psd_pkg::PARAM_W'(1 << psd_pkg::PARAM_FRAC)
	                                 : {1'b0, cell_w[NCELL].quot};

	always_ff @(posedge clk) begin
		if (ce) begin
			prx_s4  <= $signed({1'b0, t_c}) * cell_w[NCELL].dx;
			pry_s4  <= $signed({1'b0, t_c}) * cell_w[NCELL].dy;
			ax_s4   <= cell_w[NCELL].ax;
			ay_s4   <= cell_w[NCELL].ay;
			deg_s4  <= cell_w[NCELL].deg;
			degd_s4 <= cell_w[NCELL].deg_dist;
		end
	end

	// stage 5: offsets, magnitude, truncate to 8 fractional bits
	always_comb begin
		ox_c = ($signed({{2{ax_s4[DW-1]}}, ax_s4}) <<< psd_pkg::PARAM_FRAC)
		       - (DW+psd_pkg::PARAM_W+2)'(prx_s4);
		oy_c = ($signed({{2{ay_s4[DW-1]}}, ay_s4}) <<< psd_pkg::PARAM_FRAC)
		       - (DW+psd_pkg::PARAM_W+2)'(pry_s4);
		mx_c = ox_c[DW+psd_pkg::PARAM_W+1] ? -ox_c : ox_c;
		my_c = oy_c[DW+psd_pkg::PARAM_W+1] ? -oy_c : oy_c;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			qx_s5   <= 24'(mx_c >> psd_pkg::DROP);
			qy_s5   <= 24'(my_c >> psd_pkg::DROP);
			deg_s5  <= deg_s4;
			degd_s5 <= degd_s4;
		end
	end

	// stage 6: squares
	always_ff @(posedge clk) begin
		if (ce) begin
			qqx_s6  <= qx_s5 * qx_s5;
			qqy_s6  <= qy_s5 * qy_s5;
			deg_s6  <= deg_s5;
			degd_s6 <= degd_s5;
		end
	end

	// stage 7: sum, truncate, saturate, output register
	always_comb begin
		sum_c = {1'b0, qqx_s6} + {1'b0, qqy_s6};
		sh_c  = sum_c[48:8];
		if (deg_s6) begin
			dist_c = degd_s6;
		end else if (sh_c[40:psd_pkg::DIST_W] != '0) begin
			dist_c = '1;
		end else begin
			dist_c = sh_c[psd_pkg::DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			dist_s7 <= dist_c;
			deg_s7  <= deg_s6;
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata  = {6'b0, dist_s7};
	assign m_tuser  = deg_s7;

endmodule

/* hw/rtl/psd_div_cell.sv */
// one restoring division cell: produces one quotient bit per word
// depends on psd_pkg
module psd_div_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ce,
	input  logic               vld_in,
	input  psd_pkg::psd_cell_t d,
	output logic               vld_q,
	output psd_pkg::psd_cell_t q
);

	logic [psd_pkg::LEN_W:0]   r2;
	logic                      ge;
	psd_pkg::psd_cell_t        nxt;

	// shift remainder, trial subtract
	always_comb begin
		r2  = {d.rem, 1'b0};
		ge  = r2 >= {1'b0, d.len};
		nxt = d;
		if (ge) begin
			nxt.rem = psd_pkg::LEN_W'(r2 - {1'b0, d.len});
		end else begin
			nxt.rem = r2[psd_pkg::LEN_W-1:0];
		end
		nxt.quot = {d.quot[psd_pkg::PARAM_FRAC-2:0], ge};
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ce) begin
			vld_q <= vld_in;
		end
	end

	// word register
	always_ff @(posedge clk) begin
		if (ce) begin
			q <= nxt;
		end
	end

endmodule

/* sim/tb_point_segment_distance_sq.sv */
`timescale 1ns / 100ps
// self-checking bench for the point to segment squared distance block
// depends on psd_pkg and point_segment_distance_sq; drives words, checks results
module tb_point_segment_distance_sq;

	typedef struct packed {
		logic signed [15:0] ey;
		logic signed [15:0] ex;
		logic signed [15:0] sy;
		logic signed [15:0] sx;
		logic signed [15:0] py;
		logic signed [15:0] px;
	} seg_query_t;

	typedef struct {
		logic [psd_pkg::DIST_W-1:0] distance;
		logic                       deg;
	} dist_result_t;

	localparam int  CYCLE_LIMIT = 400000;
	localparam int  DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;

	seg_query_t   query_q[$];
	dist_result_t dist_q[$];
	logic [15:0]  limit_model;
	int           fail_count;
	int           cycle_count;
	int           src_gap;
	int           snk_gap;
	bit           idle_src;
	bit           idle_snk;

	point_segment_distance_sq u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// predicted squared distance for one query under the current limit
	function automatic dist_result_t predict_distance(seg_query_t q);
		logic signed [63:0] dx, dy, ax, ay, dot, ox, oy;
		logic [63:0] len_sq, t, qx, qy, d;
		dist_result_t r;
		dx = 64'(q.ex) - 64'(q.sx);
		dy = 64'(q.ey) - 64'(q.sy);
		ax = 64'(q.px) - 64'(q.sx);
		ay = 64'(q.py) - 64'(q.sy);
		len_sq = dx * dx + dy * dy;
		if (len_sq <= 64'(limit_model)) begin
			d = ax * ax + ay * ay;
			r.distance = (d > 64'h3_FFFF_FFFF) ? '1 : d[psd_pkg::DIST_W-1:0];
			r.deg = 1'b1;
			return r;
		end
		dot = ax * dx + ay * dy;
		if (dot <= 0)
			t = 0;
		else if (dot >= len_sq)
			t = 64'd1 << psd_pkg::PARAM_FRAC;
		else
			t = (64'(dot) << psd_pkg::PARAM_FRAC) / len_sq;
		ox = (ax <<< psd_pkg::PARAM_FRAC) - $signed(t) * dx;
		oy = (ay <<< psd_pkg::PARAM_FRAC) - $signed(t) * dy;
		qx = ((ox < 0) ? -ox : ox) >> psd_pkg::DROP;
		qy = ((oy < 0) ? -oy : oy) >> psd_pkg::DROP;
		d = (qx * qx + qy * qy) >> 8;
		r.distance = (d > 64'h3_FFFF_FFFF) ? '1 : d[psd_pkg::DIST_W-1:0];
		r.deg = 1'b0;
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [15:0] rand_coord();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return 16'sh7FFF;
		if (roll == 1) return -16'sh8000;
		if (roll < 5) return 16'($urandom_range(0, 255)) - 16'sd128;
		return 16'($urandom);
	endfunction

	// random query: random endpoints for half, tiny or identical segments for the rest
	function automatic seg_query_t rand_query();
		seg_query_t q;
		q.px = rand_coord(); q.py = rand_coord();
		q.sx = rand_coord(); q.sy = rand_coord();
		case ($urandom_range(0, 3))
			0: begin q.ex = q.sx; q.ey = q.sy; end
			1: begin
				q.ex = q.sx + 16'($urandom_range(0, 8)) - 16'sd4;
				q.ey = q.sy + 16'($urandom_range(0, 8)) - 16'sd4;
			end
			default: begin q.ex = rand_coord(); q.ey = rand_coord(); end
		endcase
		return q;
	endfunction

	function automatic seg_query_t mk(int px, int py, int sx, int sy, int ex, int ey);
		seg_query_t q;
		q.px = 16'(px); q.py = 16'(py); q.sx = 16'(sx);
		q.sy = 16'(sy); q.ex = 16'(ex); q.ey = 16'(ey);
		return q;
	endfunction

	// driver: source side with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				dist_q.push_back(predict_distance(seg_query_t'(s_tdata)));
				void'(query_q.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				// hold the word
			end else if (src_gap > 0 || idle_src) begin
				s_tvalid <= 1'b0;
				if (src_gap > 0) src_gap <= src_gap - 1;
			end else if ((s_tvalid && s_tready) ? query_q.size() > 1 : query_q.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= (s_tvalid && s_tready) ? query_q[1] : query_q[0];
				src_gap  <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: sink side with random stalls and result checks
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (dist_q.size() == 0) begin
					$display("%0t: unexpected word dist=%0h deg=%0b", $time,
						m_tdata[psd_pkg::DIST_W-1:0], m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					if (dist_q[0].distance !== m_tdata[psd_pkg::DIST_W-1:0]
						|| dist_q[0].deg !== m_tuser
						|| m_tdata[39:psd_pkg::DIST_W] !== '0) begin
						$display("%0t: expected dist=%0h deg=%0b, got dist=%0h deg=%0b pad=%0h",
							$time, dist_q[0].distance, dist_q[0].deg,
							m_tdata[psd_pkg::DIST_W-1:0], m_tuser,
							m_tdata[39:psd_pkg::DIST_W]);
						fail_count <= fail_count + 1;
					end
					void'(dist_q.pop_front());
				end
			end
			if (snk_gap > 0 || idle_snk) begin
				m_tready <= 1'b0;
				if (snk_gap > 0) snk_gap <= snk_gap - 1;
			end else begin
				m_tready <= 1'b1;
				snk_gap  <= pick_gap();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("point_segment_distance_sq regression: fail");
			$finish;
		end
	end

	task automatic wait_idle();
		while (query_q.size() != 0 || s_tvalid || dist_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		limit_model = value;
	endtask

	task automatic run_random(int count, bit calm);
		idle_src = calm;
		idle_snk = 1'b0;
		for (int i = 0; i < count; i++)
			query_q.push_back(rand_query());
		while (query_q.size() != 0) begin
			@(posedge clk);
			if (calm) begin
				// source rests now and then
				idle_src = ($urandom_range(0, 15) == 0);
			end else begin
				// source never rests in this run; only the random gaps remain
				idle_src = 1'b0;
			end
		end
	endtask

	// stimulus
	initial begin
		logic [15:0] limits[5];
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_wdata   = '0;
		fail_count  = 0;
		cycle_count = 0;
		idle_src    = 1'b0;
		idle_snk    = 1'b0;
		limit_model = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: before start, past end, interior, zero length, extremes
		query_q.push_back(mk(-64, 0, 0, 0, 160, 0));
		query_q.push_back(mk(400, 32, 0, 0, 160, 0));
		query_q.push_back(mk(80, 48, 0, 0, 160, 0));
		query_q.push_back(mk(17, 5, 3, 3, 3, 3));
		query_q.push_back(mk(0, 0, 0, 0, 0, 0));
		query_q.push_back(mk(32767, 32767, -32768, -32768, -32768, -32768));
		query_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, -32768));
		query_q.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767));
		query_q.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767));
		query_q.push_back(mk(5, 7, 1, 1, 2, 1));
		query_q.push_back(mk(3, -9, 0, 0, 1, 1));
		query_q.push_back(mk(100, 100, 0, 0, 200, 200));
		query_q.push_back(mk(-1, -1, -32768, 32767, 32767, -32768));
		wait_idle();

		limits[0] = 16'd1;
		limits[1] = 16'd65535;
		limits[2] = 16'd25;
		limits[3] = 16'd0;
		limits[4] = 16'd300;
		for (int p = 0; p < 5; p++) begin
			write_limit(limits[p]);
			if (p == 1) begin
				query_q.push_back(mk(9, 9, 0, 0, 255, 0));
				query_q.push_back(mk(9, 9, 0, 0, 256, 0));
			end
			run_random(140, 1'b0);
			run_random(130, p[0]);
			wait_idle();
		end

		if (fail_count == 0)
			$display("point_segment_distance_sq regression: pass");
		else
			$display("point_segment_distance_sq regression: fail");
		$finish;
	end

endmodule
